>>> hw/rtl/mlcpd_pkg.sv
// Shared constants, codes and types of the LED current regulator.
package mlcpd_pkg;

  localparam int SAMPLES_PER_BLOCK_DEF = 32;
  localparam int LED_CHANNELS_DEF      = 4;
  localparam int ADC_WIDTH_DEF         = 10;

  localparam int GOAL_REGS   = 4;
  localparam int REG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int MPLIER_W    = 16;
  localparam int CUR_W       = 16;
  localparam int PW_W        = 15;
  localparam int GAIN_DIV_W  = 23;
  localparam int PD_MUL_W    = 26;
  localparam int PD_SHIFT    = 10;

  localparam logic [15:0] SUPPLY_RESET = 16'd50000;
  localparam logic [15:0] PW_LIMIT     = 16'd30000;
  localparam logic [15:0] GAIN_P       = 16'd350;
  localparam logic [15:0] GAIN_D       = 16'd450;
  localparam logic [15:0] AMP_X49      = 16'd49;
  localparam int          SCALE_DIV    = 10;
  localparam int          GAIN_X49     = 49;
  localparam int          THRESH_X49   = 20;
  localparam int          THRESH_X5    = 200;

  localparam logic [CFG_IDX_W-1:0] REG_GOAL0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY = 3'd4;

  localparam logic [1:0] RNG_X49    = 2'd0;
  localparam logic [1:0] RNG_X5     = 2'd1;
  localparam logic [1:0] RNG_DIRECT = 2'd2;

  localparam logic KIND_SELECT = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG,
    S_VOLT,
    S_SCALE,
    S_GAIN,
    S_ERR,
    S_PTERM,
    S_DTERM,
    S_PUT
  } state_t;

endpackage

>>> hw/rtl/mlcpd_in_if.sv
// Input channel carrying command words and ADC readings.
interface mlcpd_in_if #(
  parameter int ADC_W = mlcpd_pkg::ADC_WIDTH_DEF
);
  logic             valid;
  logic             ready;
  logic             command;
  logic [ADC_W-1:0] adc_value;

  modport source (output valid, output command, output adc_value, input ready);
  modport sink   (input valid, input command, input adc_value, output ready);
endinterface

>>> hw/rtl/mlcpd_out_if.sv
// Result channel carrying range reports and pulse width updates.
interface mlcpd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [1:0]                   led_channel;
  logic [1:0]                   amp_range;
  logic [mlcpd_pkg::CUR_W-1:0]  current_ua;
  logic [mlcpd_pkg::PW_W-1:0]   pulse_width;

  modport source (output valid, output kind, output led_channel, output amp_range,
                  output current_ua, output pulse_width, input ready);
  modport sink   (input valid, input kind, input led_channel, input amp_range,
                  input current_ua, input pulse_width, output ready);
endinterface

>>> hw/rtl/mlcpd_cfg_if.sv
// Configuration write channel carrying a register index and write data.
interface mlcpd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mlcpd_pkg::CFG_IDX_W-1:0]  index;
  logic [mlcpd_pkg::REG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/multichannel_led_current_pd_loop.sv
// Top level of the multichannel LED current regulator with its serial arithmetic unit.
// A start word's report goes through the S_PUT state into the output register, S_PUT waiting
// while an earlier result is held; a sample word that does not close a block is taken every cycle
// while idle. The closing word's update is built by the serial divider and the shift-add
// multiplier while the input waits; the x49 range adds a division, x5 a multiply and a divide.
// Synchronous reset clears the control state, the goals, the error and pulse width stores.
module multichannel_led_current_pd_loop #(
  parameter int SAMPLES_PER_BLOCK = mlcpd_pkg::SAMPLES_PER_BLOCK_DEF,
  parameter int LED_CHANNELS      = mlcpd_pkg::LED_CHANNELS_DEF,
  parameter int ADC_WIDTH         = mlcpd_pkg::ADC_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mlcpd_in_if.sink     in_ch,
  mlcpd_out_if.source  out_ch,
  mlcpd_cfg_if.sink    cfg_ch
);

  localparam int CH_W    = (LED_CHANNELS > 1) ? $clog2(LED_CHANNELS) : 1;
  localparam int CNT_W   = $clog2(SAMPLES_PER_BLOCK);
  localparam int SUM_W   = ADC_WIDTH + $clog2(SAMPLES_PER_BLOCK);
  localparam int DIV_W   = (SUM_W > mlcpd_pkg::GAIN_DIV_W) ? SUM_W : mlcpd_pkg::GAIN_DIV_W;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int DIVMAX  = (SAMPLES_PER_BLOCK > mlcpd_pkg::GAIN_X49) ? SAMPLES_PER_BLOCK
                                                                     : mlcpd_pkg::GAIN_X49;
  localparam int REM_W   = $clog2(DIVMAX) + 1;
  localparam int MUL_W   = (mlcpd_pkg::REG_W + ADC_WIDTH > mlcpd_pkg::PD_MUL_W)
                           ? mlcpd_pkg::REG_W + ADC_WIDTH : mlcpd_pkg::PD_MUL_W;
  localparam int UA_W    = mlcpd_pkg::CUR_W + 1;

  mlcpd_pkg::state_t state_r, state_nxt;

  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [1:0]        rng_r, rng_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [15:0]       goal_r [mlcpd_pkg::GOAL_REGS];
  logic [15:0]       goal_nxt [mlcpd_pkg::GOAL_REGS];
  logic [15:0]       supply_r, supply_nxt;
  logic [15:0]       perr_r [LED_CHANNELS];
  logic [15:0]       perr_nxt [LED_CHANNELS];
  logic [mlcpd_pkg::PW_W-1:0] pws_r [LED_CHANNELS];
  logic [mlcpd_pkg::PW_W-1:0] pws_nxt [LED_CHANNELS];

  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [REM_W-1:0]  dsor_r, dsor_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [MUL_W-1:0]  mcand_r, mcand_nxt;
  logic [MUL_W-1:0]  acc_r, acc_nxt;
  logic [mlcpd_pkg::MPLIER_W-1:0] mplier_r, mplier_nxt;

  logic [15:0]       cur_r, cur_nxt;
  logic [15:0]       err_r, err_nxt;
  logic [15:0]       derr_r, derr_nxt;
  logic [15:0]       pterm_r, pterm_nxt;

  logic              res_kind_r, res_kind_nxt;
  logic [1:0]        res_rng_r, res_rng_nxt;
  logic [15:0]       res_cur_r, res_cur_nxt;
  logic [mlcpd_pkg::PW_W-1:0] res_pw_r, res_pw_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [1:0]        out_ch_r, out_ch_nxt;
  logic [1:0]        out_rng_r, out_rng_nxt;
  logic [15:0]       out_cur_r, out_cur_nxt;
  logic [mlcpd_pkg::PW_W-1:0] out_pw_r, out_pw_nxt;

  logic              in_fire;
  logic              cfg_fire;
  logic [REM_W-1:0]  trial;
  logic              trial_ge;
  logic [MUL_W-1:0]  mul_sum;
  logic [SUM_W-1:0]  sum_add;
  logic [7:0]        ch_wide;
  logic [15:0]       goal_sel;
  logic [15:0]       volt;
  logic [UA_W-1:0]   ua;
  logic [15:0]       dterm;
  logic [15:0]       pw_new;

  assign in_ch.ready   = (state_r == mlcpd_pkg::S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign cfg_fire      = cfg_ch.valid && cfg_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.led_channel = out_ch_r;
  assign out_ch.amp_range   = out_rng_r;
  assign out_ch.current_ua  = out_cur_r;
  assign out_ch.pulse_width = out_pw_r;

  assign trial    = {rem_r[REM_W-2:0], dvd_r[DIV_W-1]};
  assign trial_ge = (trial >= dsor_r);
  assign mul_sum  = mplier_r[0] ? (acc_r + mcand_r) : acc_r;
  assign sum_add  = sum_r + SUM_W'(in_ch.adc_value);
  assign ch_wide  = 8'(ch_r);
  assign volt     = acc_r[ADC_WIDTH +: 16];
  assign ua       = {volt, 1'b0};
  assign dterm    = acc_r[mlcpd_pkg::PD_SHIFT +: 16];
  assign pw_new   = 16'(pws_r[ch_r]) + pterm_r + dterm;

  always_comb begin
    goal_sel = '0;
    for (int i = 0; i < mlcpd_pkg::GOAL_REGS; i++) begin
      if (32'(ch_r) == 32'(i)) begin
        goal_sel = goal_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlcpd_pkg::S_IDLE;
      ch_r        <= '0;
      rng_r       <= mlcpd_pkg::RNG_X49;
      cnt_r       <= '0;
      sum_r       <= '0;
      supply_r    <= mlcpd_pkg::SUPPLY_RESET;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mlcpd_pkg::GOAL_REGS; i++) begin
        goal_r[i] <= '0;
      end
      for (int i = 0; i < LED_CHANNELS; i++) begin
        perr_r[i] <= '0;
        pws_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      rng_r       <= rng_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      supply_r    <= supply_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
      goal_r      <= goal_nxt;
      perr_r      <= perr_nxt;
      pws_r       <= pws_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dsor_r     <= dsor_nxt;
    mcand_r    <= mcand_nxt;
    acc_r      <= acc_nxt;
    mplier_r   <= mplier_nxt;
    cur_r      <= cur_nxt;
    err_r      <= err_nxt;
    derr_r     <= derr_nxt;
    pterm_r    <= pterm_nxt;
    res_kind_r <= res_kind_nxt;
    res_rng_r  <= res_rng_nxt;
    res_cur_r  <= res_cur_nxt;
    res_pw_r   <= res_pw_nxt;
    out_kind_r <= out_kind_nxt;
    out_ch_r   <= out_ch_nxt;
    out_rng_r  <= out_rng_nxt;
    out_cur_r  <= out_cur_nxt;
    out_pw_r   <= out_pw_nxt;
  end

  always_comb begin
    goal_nxt   = goal_r;
    supply_nxt = supply_r;
    if (cfg_fire) begin
      unique case (cfg_ch.index)
        mlcpd_pkg::REG_GOAL0:  goal_nxt[0] = cfg_ch.data;
        mlcpd_pkg::REG_GOAL1:  goal_nxt[1] = cfg_ch.data;
        mlcpd_pkg::REG_GOAL2:  goal_nxt[2] = cfg_ch.data;
        mlcpd_pkg::REG_GOAL3:  goal_nxt[3] = cfg_ch.data;
        mlcpd_pkg::REG_SUPPLY: supply_nxt  = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    rng_nxt       = rng_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    perr_nxt      = perr_r;
    pws_nxt       = pws_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dsor_nxt      = dsor_r;
    dcnt_nxt      = dcnt_r;
    mcand_nxt     = mcand_r;
    acc_nxt       = acc_r;
    mplier_nxt    = mplier_r;
    cur_nxt       = cur_r;
    err_nxt       = err_r;
    derr_nxt      = derr_r;
    pterm_nxt     = pterm_r;
    res_kind_nxt  = res_kind_r;
    res_rng_nxt   = res_rng_r;
    res_cur_nxt   = res_cur_r;
    res_pw_nxt    = res_pw_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_ch_nxt    = out_ch_r;
    out_rng_nxt   = out_rng_r;
    out_cur_nxt   = out_cur_r;
    out_pw_nxt    = out_pw_r;

    if ((state_r == mlcpd_pkg::S_AVG || state_r == mlcpd_pkg::S_GAIN) && dcnt_r != '0) begin
      rem_nxt  = trial_ge ? (trial - dsor_r) : trial;
      dvd_nxt  = {dvd_r[DIV_W-2:0], trial_ge};
      dcnt_nxt = dcnt_r - 1'b1;
    end
    if ((state_r == mlcpd_pkg::S_VOLT || state_r == mlcpd_pkg::S_SCALE ||
         state_r == mlcpd_pkg::S_PTERM || state_r == mlcpd_pkg::S_DTERM) &&
        mplier_r != '0) begin
      acc_nxt    = mul_sum;
      mcand_nxt  = {mcand_r[MUL_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[mlcpd_pkg::MPLIER_W-1:1]};
    end

    unique case (state_r)
      mlcpd_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.command == mlcpd_pkg::CMD_START) begin
            ch_nxt = (32'(ch_r) == LED_CHANNELS - 1) ? '0 : ch_r + 1'b1;
            if (in_ch.adc_value < ADC_WIDTH'(mlcpd_pkg::THRESH_X49)) begin
              rng_nxt = mlcpd_pkg::RNG_X49;
            end else if (in_ch.adc_value < ADC_WIDTH'(mlcpd_pkg::THRESH_X5)) begin
              rng_nxt = mlcpd_pkg::RNG_X5;
            end else begin
              rng_nxt = mlcpd_pkg::RNG_DIRECT;
            end
            cnt_nxt      = '0;
            sum_nxt      = '0;
            res_kind_nxt = mlcpd_pkg::KIND_SELECT;
            res_rng_nxt  = rng_nxt;
            res_cur_nxt  = '0;
            res_pw_nxt   = '0;
            state_nxt    = mlcpd_pkg::S_PUT;
          end else if (32'(cnt_r) == SAMPLES_PER_BLOCK - 1) begin
            cnt_nxt   = '0;
            sum_nxt   = '0;
            dvd_nxt   = DIV_W'(sum_add);
            rem_nxt   = '0;
            dsor_nxt  = REM_W'(SAMPLES_PER_BLOCK);
            dcnt_nxt  = DCNT_W'(DIV_W);
            state_nxt = mlcpd_pkg::S_AVG;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            sum_nxt = sum_add;
          end
        end
      end
      mlcpd_pkg::S_AVG: begin
        if (dcnt_r == '0) begin
          mcand_nxt  = MUL_W'(dvd_r[ADC_WIDTH-1:0]);
          mplier_nxt = supply_r;
          acc_nxt    = '0;
          state_nxt  = mlcpd_pkg::S_VOLT;
        end
      end
      mlcpd_pkg::S_VOLT: begin
        if (mplier_r == '0) begin
          case (rng_r)
            mlcpd_pkg::RNG_X49: begin
              dvd_nxt   = DIV_W'(ua);
              rem_nxt   = '0;
              dsor_nxt  = REM_W'(mlcpd_pkg::GAIN_X49);
              dcnt_nxt  = DCNT_W'(DIV_W);
              state_nxt = mlcpd_pkg::S_GAIN;
            end
            mlcpd_pkg::RNG_X5: begin
              mcand_nxt  = MUL_W'(ua);
              mplier_nxt = mlcpd_pkg::AMP_X49;
              acc_nxt    = '0;
              state_nxt  = mlcpd_pkg::S_SCALE;
            end
            default: begin
              cur_nxt   = ua[15:0];
              state_nxt = mlcpd_pkg::S_ERR;
            end
          endcase
        end
      end
      mlcpd_pkg::S_SCALE: begin
        if (mplier_r == '0) begin
          dvd_nxt   = DIV_W'(acc_r[mlcpd_pkg::GAIN_DIV_W-1:0]);
          rem_nxt   = '0;
          dsor_nxt  = REM_W'(mlcpd_pkg::SCALE_DIV);
          dcnt_nxt  = DCNT_W'(DIV_W);
          state_nxt = mlcpd_pkg::S_GAIN;
        end
      end
      mlcpd_pkg::S_GAIN: begin
        if (dcnt_r == '0) begin
          cur_nxt   = dvd_r[15:0];
          state_nxt = mlcpd_pkg::S_ERR;
        end
      end
      mlcpd_pkg::S_ERR: begin
        err_nxt    = goal_sel - cur_r;
        derr_nxt   = err_nxt - perr_r[ch_r];
        mcand_nxt  = {{(MUL_W-16){err_nxt[15]}}, err_nxt};
        mplier_nxt = mlcpd_pkg::GAIN_P;
        acc_nxt    = '0;
        state_nxt  = mlcpd_pkg::S_PTERM;
      end
      mlcpd_pkg::S_PTERM: begin
        if (mplier_r == '0) begin
          pterm_nxt  = acc_r[mlcpd_pkg::PD_SHIFT +: 16];
          mcand_nxt  = {{(MUL_W-16){derr_r[15]}}, derr_r};
          mplier_nxt = mlcpd_pkg::GAIN_D;
          acc_nxt    = '0;
          state_nxt  = mlcpd_pkg::S_DTERM;
        end
      end
      mlcpd_pkg::S_DTERM: begin
        if (mplier_r == '0) begin
          perr_nxt[ch_r] = err_r;
          pws_nxt[ch_r]  = (pw_new > mlcpd_pkg::PW_LIMIT) ? '0 : pw_new[mlcpd_pkg::PW_W-1:0];
          res_kind_nxt   = mlcpd_pkg::KIND_UPDATE;
          res_rng_nxt    = rng_r;
          res_cur_nxt    = cur_r;
          res_pw_nxt     = pws_nxt[ch_r];
          state_nxt      = mlcpd_pkg::S_PUT;
        end
      end
      mlcpd_pkg::S_PUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_ch_nxt    = ch_wide[1:0];
          out_rng_nxt   = res_rng_r;
          out_cur_nxt   = res_cur_r;
          out_pw_nxt    = res_pw_r;
          state_nxt     = mlcpd_pkg::S_IDLE;
        end
      end
      default: state_nxt = mlcpd_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_start_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.command == mlcpd_pkg::CMD_START) |=> (state_r == mlcpd_pkg::S_PUT))
    else $error("start word did not lead to a report");

  a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.command == mlcpd_pkg::CMD_SAMPLE &&
     32'(cnt_r) == SAMPLES_PER_BLOCK - 1)
    |=> (state_r == mlcpd_pkg::S_AVG && cnt_r == '0 && sum_r == '0))
    else $error("completed block did not start the conversion");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) < SAMPLES_PER_BLOCK)
    else $error("sample count beyond block length");

  a_divider_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mlcpd_pkg::S_IDLE) |-> (dcnt_r == '0))
    else $error("divider still running while idle");

  a_pw_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == mlcpd_pkg::KIND_UPDATE)
    |-> (16'(out_pw_r) <= mlcpd_pkg::PW_LIMIT))
    else $error("pulse width above limit");
`endif

endmodule

>>> tb/sv/testbench.sv
// Testbench of the LED current regulator: random and directed words checked against a predictor.
module testbench;

  localparam int SAMPLES      = mlcpd_pkg::SAMPLES_PER_BLOCK_DEF;
  localparam int CHANNELS     = mlcpd_pkg::LED_CHANNELS_DEF;
  localparam int ADC_W        = mlcpd_pkg::ADC_WIDTH_DEF;
  localparam int ADC_MAX      = (1 << ADC_W) - 1;
  localparam int SETTLE_CYCLES = 150;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic            kind;
    logic [1:0]      chan;
    logic [1:0]      rng;
    logic [mlcpd_pkg::CUR_W-1:0] cur;
    logic [mlcpd_pkg::PW_W-1:0]  pw;
  } led_report_t;

  logic clk = 1'b0;
  logic rst_n;

  mlcpd_in_if #(.ADC_W(ADC_W)) in_if ();
  mlcpd_out_if out_if ();
  mlcpd_cfg_if cfg_if ();

  multichannel_led_current_pd_loop u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Shadow of the configuration and the regulator state.
  logic [mlcpd_pkg::REG_W-1:0] goal_reg [mlcpd_pkg::GOAL_REGS];
  logic [mlcpd_pkg::REG_W-1:0] supply_reg;
  logic [1:0]       cur_chan;
  logic [1:0]       cur_range;
  int               block_count;
  int               block_sum;
  logic [15:0]      last_err [CHANNELS];
  logic [15:0]      pw_reg [CHANNELS];

  led_report_t pending_reports [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int held_cycles = 0;
  int words_sent = 0;
  int selects_seen = 0;
  int updates_seen = 0;
  int cfg_writes = 0;
  int fail_count = 0;
  int cycle_count = 0;

  function automatic logic [mlcpd_pkg::CUR_W-1:0] sense_current(input int sum);
    int unsigned avg;
    int unsigned mv;
    int unsigned ua;
    avg = sum / SAMPLES;
    mv  = (int'(supply_reg) * avg) >> ADC_W;
    ua  = (mv * 100) / 50;
    if (cur_range == mlcpd_pkg::RNG_X49) begin
      ua = ua / mlcpd_pkg::GAIN_X49;
    end else if (cur_range == mlcpd_pkg::RNG_X5) begin
      ua = (mlcpd_pkg::GAIN_X49 * ua) / mlcpd_pkg::SCALE_DIV;
    end
    return ua[mlcpd_pkg::CUR_W-1:0];
  endfunction

  function automatic logic [mlcpd_pkg::PW_W-1:0] pd_step(input logic [1:0] ch,
                                                         input logic [15:0] cur);
    logic [15:0] err;
    logic [15:0] derr;
    logic [15:0] pw;
    int          p_term;
    int          d_term;
    err    = goal_reg[ch] - cur;
    derr   = err - last_err[ch];
    last_err[ch] = err;
    p_term = (int'(mlcpd_pkg::GAIN_P) * int'($signed(err))) >>> mlcpd_pkg::PD_SHIFT;
    d_term = (int'(mlcpd_pkg::GAIN_D) * int'($signed(derr))) >>> mlcpd_pkg::PD_SHIFT;
    pw     = pw_reg[ch] + 16'(p_term + d_term);
    if (pw > mlcpd_pkg::PW_LIMIT) pw = 16'd0;
    pw_reg[ch] = pw;
    return pw[mlcpd_pkg::PW_W-1:0];
  endfunction

  function automatic void regulate_word(input logic cmd, input logic [ADC_W-1:0] adc);
    led_report_t r;
    if (cmd == mlcpd_pkg::CMD_START) begin
      cur_chan  = (int'(cur_chan) >= CHANNELS - 1) ? 2'd0 : cur_chan + 2'd1;
      cur_range = (adc < mlcpd_pkg::THRESH_X49) ? mlcpd_pkg::RNG_X49 :
                  (adc < mlcpd_pkg::THRESH_X5) ? mlcpd_pkg::RNG_X5 : mlcpd_pkg::RNG_DIRECT;
      block_count = 0;
      block_sum   = 0;
      r = '{kind: mlcpd_pkg::KIND_SELECT, chan: cur_chan, rng: cur_range, cur: '0, pw: '0};
      pending_reports.push_back(r);
    end else begin
      block_sum   += adc;
      block_count += 1;
      if (block_count >= SAMPLES) begin
        r.kind = mlcpd_pkg::KIND_UPDATE;
        r.chan = cur_chan;
        r.rng  = cur_range;
        r.cur  = sense_current(block_sum);
        r.pw   = pd_step(cur_chan, r.cur);
        block_count = 0;
        block_sum   = 0;
        pending_reports.push_back(r);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s wrong, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin
    led_report_t e;
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending_reports.size());
      $display("multichannel_led_current_pd_loop: mismatch");
      $finish;
    end
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result word with nothing outstanding, kind %0d channel %0d",
                 $time, out_if.kind, out_if.led_channel);
        fail_count++;
      end else begin
        e = pending_reports.pop_front();
        check_field("kind", e.kind, out_if.kind);
        check_field("led_channel", e.chan, out_if.led_channel);
        check_field("amp_range", e.rng, out_if.amp_range);
        check_field("current_ua", e.cur, out_if.current_ua);
        check_field("pulse_width", e.pw, out_if.pulse_width);
        if (e.kind == mlcpd_pkg::KIND_UPDATE) updates_seen++;
        else selects_seen++;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_if.ready <= 1'b0;
        hold_off--;
        held_cycles++;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(input logic cmd, input logic [ADC_W-1:0] adc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= cmd;
    in_if.adc_value <= adc;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    regulate_word(cmd, adc);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [ADC_W-1:0] sample_value(input int mode, input int level);
    int v;
    case (mode)
      0: v = $urandom_range(ADC_MAX);
      1: v = level + int'($urandom_range(30)) - 15;
      2: v = $urandom_range(1) ? ADC_MAX : 0;
      default: v = level;
    endcase
    if (v < 0) v = 0;
    if (v > ADC_MAX) v = ADC_MAX;
    return v[ADC_W-1:0];
  endfunction

  function automatic logic [ADC_W-1:0] probe_value();
    int v;
    case ($urandom_range(2))
      0: v = $urandom_range(mlcpd_pkg::THRESH_X49 - 1);
      1: v = $urandom_range(mlcpd_pkg::THRESH_X5 - 1, mlcpd_pkg::THRESH_X49);
      default: v = $urandom_range(ADC_MAX, mlcpd_pkg::THRESH_X5);
    endcase
    return v[ADC_W-1:0];
  endfunction

  task automatic send_samples(input int n, input int mode, input int level);
    for (int i = 0; i < n; i++) begin
      send_word(mlcpd_pkg::CMD_SAMPLE, sample_value(mode, level));
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [mlcpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mlcpd_pkg::REG_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    if (idx == mlcpd_pkg::REG_SUPPLY) supply_reg = val;
    else goal_reg[idx[1:0]] = val;
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] g0, input logic [15:0] g1,
                            input logic [15:0] g2, input logic [15:0] g3,
                            input logic [15:0] supply);
    write_reg(mlcpd_pkg::REG_GOAL0, g0);
    write_reg(mlcpd_pkg::REG_GOAL1, g1);
    write_reg(mlcpd_pkg::REG_GOAL2, g2);
    write_reg(mlcpd_pkg::REG_GOAL3, g3);
    write_reg(mlcpd_pkg::REG_SUPPLY, supply);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [15:0] random_reg();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(3000));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic test_directed_cases();
    // Reset settings: zero goals and the default supply.
    send_word(mlcpd_pkg::CMD_START, 10'd0);
    send_samples(SAMPLES, 3, ADC_MAX);
    send_word(mlcpd_pkg::CMD_START, 10'(mlcpd_pkg::THRESH_X49 - 1));
    send_word(mlcpd_pkg::CMD_START, 10'(mlcpd_pkg::THRESH_X49));
    send_word(mlcpd_pkg::CMD_START, 10'(mlcpd_pkg::THRESH_X5 - 1));
    send_word(mlcpd_pkg::CMD_START, 10'(mlcpd_pkg::THRESH_X5));
    send_word(mlcpd_pkg::CMD_START, 10'(ADC_MAX));
    send_samples(SAMPLES, 3, ADC_MAX);
    // A start drops the partial block.
    send_samples(10, 3, ADC_MAX);
    send_word(mlcpd_pkg::CMD_START, 10'd100);
    send_samples(SAMPLES, 3, 0);
    // Further samples open a new block on the same channel.
    send_samples(SAMPLES, 3, 10'h155);
    send_samples(SAMPLES, 3, 10'h2AA);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int c = 0; c < CHANNELS; c++) begin
      send_word(mlcpd_pkg::CMD_START, 10'(ADC_MAX));
      send_samples(SAMPLES, 3, ADC_MAX);
    end
    wait_idle();
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    for (int c = 0; c < CHANNELS; c++) begin
      send_word(mlcpd_pkg::CMD_START, 10'd0);
      send_samples(SAMPLES, 0, 0);
    end
    wait_idle();
    set_config(16'd2000, 16'd40000, 16'd65535, 16'd0, 16'd50000);
    for (int c = 0; c < CHANNELS; c++) begin
      send_word(mlcpd_pkg::CMD_START, probe_value());
      send_samples(SAMPLES, 1, $urandom_range(ADC_MAX));
    end
    wait_idle();
  endtask

  task automatic run_traffic(input int n_words);
    int first;
    int pick;
    first = words_sent;
    while (words_sent - first < n_words) begin
      pick = $urandom_range(9);
      if (pick <= 6) begin
        send_word(mlcpd_pkg::CMD_START, probe_value());
        send_samples(SAMPLES, $urandom_range(2), $urandom_range(ADC_MAX));
      end else if (pick == 7) begin
        send_word(mlcpd_pkg::CMD_START, probe_value());
        send_samples($urandom_range(SAMPLES - 1, 1), 0, 0);
      end else if (pick == 8) begin
        repeat ($urandom_range(3, 1)) begin
          send_word(mlcpd_pkg::CMD_START, 10'($urandom_range(ADC_MAX)));
        end
      end else begin
        send_samples(SAMPLES, $urandom_range(2), $urandom_range(ADC_MAX));
      end
    end
  endtask

  task automatic test_random_phases();
    int send_pct [4] = '{0, 48, 0, 16};
    int recv_pct [4] = '{0, 0, 48, 16};
    for (int p = 0; p < 4; p++) begin
      set_config(random_reg(), random_reg(), random_reg(), random_reg(),
                 $urandom_range(1) ? 16'd50000 : random_reg());
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      run_traffic(32);
      wait_idle();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_off = HOLD_CYCLES;
    @(negedge clk);
    for (int i = 0; i < 40; i++) begin
      send_word(mlcpd_pkg::CMD_START, probe_value());
    end
    send_samples(SAMPLES, 0, 0);
    send_word(mlcpd_pkg::CMD_START, probe_value());
    wait_idle();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.command   = mlcpd_pkg::CMD_START;
    in_if.adc_value = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = mlcpd_pkg::REG_GOAL0;
    cfg_if.data     = '0;
    for (int i = 0; i < mlcpd_pkg::GOAL_REGS; i++) goal_reg[i] = '0;
    supply_reg  = mlcpd_pkg::SUPPLY_RESET;
    cur_chan    = 2'd0;
    cur_range   = mlcpd_pkg::RNG_X49;
    block_count = 0;
    block_sum   = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      last_err[i] = '0;
      pw_reg[i]   = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_config_extremes();
    test_random_phases();
    test_backpressure();

    $display("Sent %0d words over %0d register writes; checked %0d range reports and %0d updates.",
             words_sent, cfg_writes, selects_seen, updates_seen);
    $display("Receiver held off for %0d cycles; %0d field errors found.", held_cycles, fail_count);
    if (fail_count == 0) begin
      $display("multichannel_led_current_pd_loop: match");
    end else begin
      $display("multichannel_led_current_pd_loop: mismatch");
    end
    $finish;
  end

endmodule
